@@ rtl/core/hrt_pkg.sv @@
package hrt_pkg;

  // Table geometry.
  localparam int TABLE_ENTRIES = 64;
  localparam int PROCESSES     = 8;
  localparam int CODEWORDS     = 2;
  localparam int ENT_W         = $clog2(TABLE_ENTRIES);
  localparam int PID_W         = $clog2(PROCESSES);
  localparam int CW_W          = $clog2(CODEWORDS);
  localparam int REC_IDX_W     = ENT_W + PID_W + CW_W;
  localparam int REC_COUNT     = TABLE_ENTRIES * PROCESSES * CODEWORDS;
  localparam int RECS_PER_ENT  = PROCESSES * CODEWORDS;
  localparam int K_W           = PID_W + CW_W;

  // Field widths.
  localparam int RNTI_W  = 16;
  localparam int STAMP_W = 32;
  localparam int TBS_W   = 17;
  localparam int FRAME_W = 10;
  localparam int SUB_W   = 4;
  localparam int TTI_W   = 14;
  localparam int FREE_W  = 7;
  localparam int IDLE_W  = 16;

  // Entry word: user in the low bits, stamp above.
  localparam int ENT_BITS = RNTI_W + STAMP_W;

  // Record word: tbs, frame, subframe, ndi, first, decoded, busy.
  localparam int REC_BITS  = 35;
  localparam int BIT_NDI   = 31;
  localparam int BIT_FIRST = 32;
  localparam int BIT_DEC   = 33;
  localparam int BIT_BUSY  = 34;
  localparam logic [REC_BITS-1:0] REC_RESET = 35'h1_0000_0000;

  // Timing constants.
  localparam logic [TTI_W:0] RETX_GAP      = 15'd8;
  localparam logic [TTI_W:0] RETX_GAP_WRAP = 15'd10232;

  // Default register values.
  localparam logic [IDLE_W-1:0] IDLE_RESET   = 16'd1000;
  localparam logic [FREE_W-1:0] THR_RESET    = 7'd10;
  localparam logic [FREE_W-1:0] FREE_FULL    = 7'd64;

  typedef enum logic [1:0] {
    OP_CLASSIFY = 2'd0,
    OP_COMMIT   = 2'd1,
    OP_TICK     = 2'd2,
    OP_SWEEP    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    V_NEW     = 3'd0,
    V_RETX    = 3'd1,
    V_DECODED = 3'd2,
    V_BUSY    = 3'd3,
    V_FULL    = 3'd4,
    V_DONE    = 3'd5
  } verdict_t;

  localparam logic CFG_IDLE_LIMIT = 1'b0;
  localparam logic CFG_SWEEP_THR  = 1'b1;

  // Outcome of judging one stored record against a classify request.
  typedef struct packed {
    verdict_t verdict;
    logic     set_busy;
  } judge_t;

endpackage

@@ rtl/core/hrt_ram.sv @@
module hrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/hrt_judge.sv @@
module hrt_judge (
  input  logic [hrt_pkg::REC_BITS-1:0] rec,
  input  logic [hrt_pkg::TTI_W-1:0]    cur_tti,
  input  logic                         ndi_valid,
  input  logic                         ndi,
  input  logic [hrt_pkg::TBS_W-1:0]    tbs,
  output hrt_pkg::judge_t              jd
);

  logic [hrt_pkg::TBS_W-1:0]   l_tbs;
  logic [hrt_pkg::FRAME_W-1:0] l_frame;
  logic [hrt_pkg::SUB_W-1:0]   l_sub;
  logic [hrt_pkg::TTI_W-1:0]   prev_tti;
  logic                        gap_hit;
  logic                        want_new;

  assign l_tbs   = rec[16:0];
  assign l_frame = rec[26:17];
  assign l_sub   = rec[30:27];

  // TTI of the stored grant: frame times ten plus subframe.
  assign prev_tti = {1'b0, l_frame, 3'b000} + {3'b000, l_frame, 1'b0}
                  + {{(hrt_pkg::TTI_W-hrt_pkg::SUB_W){1'b0}}, l_sub};

  // The gap modulo 10240 is eight exactly when the signed difference is 8 or 8-10240.
  assign gap_hit = ({1'b0, cur_tti} == ({1'b0, prev_tti} + hrt_pkg::RETX_GAP)) ||
                   ({1'b0, prev_tti} == ({1'b0, cur_tti} + hrt_pkg::RETX_GAP_WRAP));

  assign want_new = !gap_hit || (ndi_valid && (ndi != rec[hrt_pkg::BIT_NDI])) ||
                    rec[hrt_pkg::BIT_FIRST] || (l_tbs != tbs);

  // New and retransmission claim the record; a busy record answers busy.
  always_comb begin
    jd.set_busy = 1'b0;
    if (!want_new && rec[hrt_pkg::BIT_DEC]) begin
      jd.verdict = hrt_pkg::V_DECODED;
    end else if (rec[hrt_pkg::BIT_BUSY]) begin
      jd.verdict = hrt_pkg::V_BUSY;
    end else begin
      jd.set_busy = 1'b1;
      jd.verdict  = want_new ? hrt_pkg::V_NEW : hrt_pkg::V_RETX;
    end
  end

endmodule

@@ rtl/core/harq_retransmission_tracker.sv @@
// Downlink HARQ process tracker.
// Requests enter on the in_ stream: in_tuser carries the operation (classify,
// commit, tick, sweep), in_tdata the grant fields. Each request gives exactly
// one result on the out_ stream: out_tuser holds the verdict, out_tdata the
// stored block size and the free entry count. The cfg_ channel writes the idle
// limit (index 0) and the sweep threshold (index 1); it is always ready.
// Requests are handled one at a time. Classify and commit search the 64-entry
// user memory one entry per cycle and then decide; a classify that finds its
// user also judges the stored record before its result is staged. Ticks,
// non-acting sweeps and requests for user zero go straight from accept to the
// result state, which loads the output register before the next request is taken.
// An acting sweep reads and checks each of the 64 entries in turn and clears the
// 16 records of every freed entry. After reset the block runs a clearing pass over
// all 1024 words of the record memory (and the user memory within it) with
// in_tready low; configuration writes are taken during it. A finished result is
// held in the output register until out_tready; the next request can be worked
// on meanwhile, and its result waits until the output register is free.
module harq_retransmission_tracker (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata, lowest bit up: rnti, process_id, codeword, frame_number, subframe,
  // ndi_present, ndi, tbs, first_transmission, decoded, zero fill.
  input  logic [55:0] in_tdata,
  // in_tuser: operation.
  input  logic [1:0]  in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata, lowest bit up: last_tbs, free_count.
  output logic [23:0] out_tdata,
  // out_tuser: verdict.
  output logic [2:0]  out_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_DECIDE, S_JUDGE, S_SW_RD, S_SW_CHK, S_SW_CLR, S_RESP
  } state_t;

  state_t state_r;

  // Request registers.
  hrt_pkg::op_t                  op_r;
  logic [hrt_pkg::RNTI_W-1:0]    rnti_r;
  logic [hrt_pkg::PID_W-1:0]     pid_r;
  logic [hrt_pkg::CW_W-1:0]      cw_r;
  logic [hrt_pkg::FRAME_W-1:0]   frame_r;
  logic [hrt_pkg::SUB_W-1:0]     sub_r;
  logic [hrt_pkg::TTI_W-1:0]     tti_r;
  logic                          ndi_p_r;
  logic                          ndi_r;
  logic [hrt_pkg::TBS_W-1:0]     tbs_r;
  logic                          first_r;
  logic                          dec_r;

  // Search and sweep bookkeeping.
  logic [hrt_pkg::REC_IDX_W-1:0] clr_idx_r;
  logic [hrt_pkg::ENT_W:0]       scan_r;
  logic [hrt_pkg::ENT_W-1:0]     ent_idx_r;
  logic [hrt_pkg::K_W-1:0]       k_r;
  logic [hrt_pkg::ENT_W-1:0]     hit_r;
  logic                          hit_v_r;
  logic [hrt_pkg::ENT_W-1:0]     fr_r;
  logic                          fr_v_r;

  // Block state and configuration.
  logic [hrt_pkg::STAMP_W-1:0]   tick_r;
  logic [hrt_pkg::FREE_W-1:0]    free_r;
  logic [hrt_pkg::IDLE_W-1:0]    idle_limit_r;
  logic [hrt_pkg::FREE_W-1:0]    thr_r;

  // Result staging and output registers.
  hrt_pkg::verdict_t             res_verdict_r;
  logic [hrt_pkg::TBS_W-1:0]     res_tbs_r;
  logic                          out_valid_r;
  logic [2:0]                    out_verdict_r;
  logic [hrt_pkg::TBS_W-1:0]     out_tbs_r;
  logic [hrt_pkg::FREE_W-1:0]    out_free_r;

  // Memory ports.
  logic                          ent_we;
  logic [hrt_pkg::ENT_W-1:0]     ent_waddr;
  logic [hrt_pkg::ENT_BITS-1:0]  ent_wdata;
  logic [hrt_pkg::ENT_W-1:0]     ent_raddr;
  logic [hrt_pkg::ENT_BITS-1:0]  ent_rdata;
  logic                          rec_we;
  logic [hrt_pkg::REC_IDX_W-1:0] rec_waddr;
  logic [hrt_pkg::REC_BITS-1:0]  rec_wdata;
  logic [hrt_pkg::REC_IDX_W-1:0] rec_raddr;
  logic [hrt_pkg::REC_BITS-1:0]  rec_rdata;

  logic [hrt_pkg::RNTI_W-1:0]    rd_user;
  logic [hrt_pkg::STAMP_W-1:0]   rd_stamp;
  logic [hrt_pkg::STAMP_W-1:0]   idle_age;
  logic                          expire;
  logic                          in_fire;
  logic                          resp_go;
  logic [hrt_pkg::ENT_W-1:0]     scan_ent;
  logic [hrt_pkg::FRAME_W-1:0]   in_frame;
  logic [hrt_pkg::SUB_W-1:0]     in_sub;
  hrt_pkg::judge_t               jd;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_verdict_r;
  assign out_tdata  = {out_free_r, out_tbs_r};
  assign resp_go    = !out_valid_r || out_tready;

  assign in_frame = in_tdata[29:20];
  assign in_sub   = in_tdata[33:30];
  assign rd_user  = ent_rdata[hrt_pkg::RNTI_W-1:0];
  assign rd_stamp = ent_rdata[hrt_pkg::ENT_BITS-1:hrt_pkg::RNTI_W];
  assign idle_age = tick_r - rd_stamp;
  assign expire   = (rd_user != '0) &&
                    (idle_age > {{(hrt_pkg::STAMP_W-hrt_pkg::IDLE_W){1'b0}}, idle_limit_r});
  assign scan_ent = hrt_pkg::ENT_W'(scan_r - 1'b1);

  hrt_ram #(.WIDTH(hrt_pkg::ENT_BITS), .DEPTH(hrt_pkg::TABLE_ENTRIES)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  hrt_ram #(.WIDTH(hrt_pkg::REC_BITS), .DEPTH(hrt_pkg::REC_COUNT)) u_rec_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (rec_waddr),
    .wdata (rec_wdata),
    .raddr (rec_raddr),
    .rdata (rec_rdata)
  );

  hrt_judge u_judge (
    .rec       (rec_rdata),
    .cur_tti   (tti_r),
    .ndi_valid (ndi_p_r),
    .ndi       (ndi_r),
    .tbs       (tbs_r),
    .jd        (jd)
  );

  // Memory port control for each state.
  always_comb begin
    ent_we    = 1'b0;
    ent_waddr = ent_idx_r;
    ent_wdata = '0;
    ent_raddr = ent_idx_r;
    rec_we    = 1'b0;
    rec_waddr = {hit_r, pid_r, cw_r};
    rec_wdata = hrt_pkg::REC_RESET;
    rec_raddr = {hit_r, pid_r, cw_r};
    unique case (state_r)
      S_CLEAR: begin
        rec_we    = 1'b1;
        rec_waddr = clr_idx_r;
        ent_we    = (clr_idx_r[hrt_pkg::REC_IDX_W-1:hrt_pkg::ENT_W] == '0);
        ent_waddr = clr_idx_r[hrt_pkg::ENT_W-1:0];
      end
      S_SCAN: begin
        ent_raddr = scan_r[hrt_pkg::ENT_W-1:0];
      end
      S_DECIDE: begin
        if (op_r == hrt_pkg::OP_CLASSIFY) begin
          if (!hit_v_r && fr_v_r) begin
            ent_we    = 1'b1;
            ent_waddr = fr_r;
            ent_wdata = {tick_r, rnti_r};
            rec_we    = 1'b1;
            rec_waddr = {fr_r, pid_r, cw_r};
            rec_wdata = hrt_pkg::REC_RESET;
            rec_wdata[hrt_pkg::BIT_BUSY] = 1'b1;
          end
        end else if (hit_v_r) begin
          ent_we    = 1'b1;
          ent_waddr = hit_r;
          ent_wdata = {tick_r, rnti_r};
          rec_we    = 1'b1;
          rec_wdata = {1'b0, dec_r, first_r, ndi_r, sub_r, frame_r, tbs_r};
        end
      end
      S_JUDGE: begin
        rec_we    = jd.set_busy;
        rec_wdata = rec_rdata;
        rec_wdata[hrt_pkg::BIT_BUSY] = 1'b1;
      end
      S_SW_CHK: begin
        ent_we = expire;
      end
      S_SW_CLR: begin
        rec_we    = 1'b1;
        rec_waddr = {ent_idx_r, k_r};
      end
      default: begin
      end
    endcase
  end

  // Sequencer, block state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_idx_r    <= '0;
      tick_r       <= '0;
      free_r       <= hrt_pkg::FREE_FULL;
      idle_limit_r <= hrt_pkg::IDLE_RESET;
      thr_r        <= hrt_pkg::THR_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == hrt_pkg::CFG_IDLE_LIMIT) begin
          idle_limit_r <= cfg_data;
        end else begin
          thr_r <= cfg_data[hrt_pkg::FREE_W-1:0];
        end
      end
      // A result leaving while a new one is loaded is handled in S_RESP.
      if (out_valid_r && out_tready && (state_r != S_RESP)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_idx_r <= clr_idx_r + 1'b1;
          if (clr_idx_r == hrt_pkg::REC_IDX_W'(hrt_pkg::REC_COUNT - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            op_r      <= hrt_pkg::op_t'(in_tuser);
            rnti_r    <= in_tdata[15:0];
            pid_r     <= in_tdata[18:16];
            cw_r      <= in_tdata[19];
            frame_r   <= in_frame;
            sub_r     <= in_sub;
            tti_r     <= {1'b0, in_frame, 3'b000} + {3'b000, in_frame, 1'b0}
                       + {{(hrt_pkg::TTI_W-hrt_pkg::SUB_W){1'b0}}, in_sub};
            ndi_p_r   <= in_tdata[34];
            ndi_r     <= in_tdata[35];
            tbs_r     <= in_tdata[52:36];
            first_r   <= in_tdata[53];
            dec_r     <= in_tdata[54];
            scan_r    <= '0;
            ent_idx_r <= '0;
            hit_v_r   <= 1'b0;
            fr_v_r    <= 1'b0;
            res_tbs_r <= '0;
            unique case (hrt_pkg::op_t'(in_tuser))
              hrt_pkg::OP_CLASSIFY: begin
                if (in_tdata[15:0] == '0) begin
                  res_verdict_r <= hrt_pkg::V_FULL;
                  state_r       <= S_RESP;
                end else begin
                  res_verdict_r <= hrt_pkg::V_DONE;
                  state_r       <= S_SCAN;
                end
              end
              hrt_pkg::OP_COMMIT: begin
                res_verdict_r <= hrt_pkg::V_DONE;
                state_r <= (in_tdata[15:0] == '0) ? S_RESP : S_SCAN;
              end
              hrt_pkg::OP_TICK: begin
                res_verdict_r <= hrt_pkg::V_DONE;
                tick_r  <= tick_r + 1'b1;
                state_r <= S_RESP;
              end
              hrt_pkg::OP_SWEEP: begin
                res_verdict_r <= hrt_pkg::V_DONE;
                state_r <= (free_r <= thr_r) ? S_SW_RD : S_RESP;
              end
            endcase
          end
        end
        S_SCAN: begin
          // Entry scan_r-1 is on the read port; the last match or free slot wins.
          scan_r <= scan_r + 1'b1;
          if (scan_r != '0) begin
            if (rd_user == rnti_r) begin
              hit_r   <= scan_ent;
              hit_v_r <= 1'b1;
            end else if (rd_user == '0) begin
              fr_r   <= scan_ent;
              fr_v_r <= 1'b1;
            end
          end
          if (scan_r == (hrt_pkg::ENT_W+1)'(hrt_pkg::TABLE_ENTRIES)) begin
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (op_r == hrt_pkg::OP_CLASSIFY) begin
            if (hit_v_r) begin
              state_r <= S_JUDGE;
            end else begin
              if (fr_v_r) begin
                res_verdict_r <= hrt_pkg::V_NEW;
                if (free_r != '0) begin
                  free_r <= free_r - 1'b1;
                end
              end else begin
                res_verdict_r <= hrt_pkg::V_FULL;
              end
              state_r <= S_RESP;
            end
          end else begin
            if (hit_v_r) begin
              res_tbs_r <= tbs_r;
            end
            state_r <= S_RESP;
          end
        end
        S_JUDGE: begin
          res_verdict_r <= jd.verdict;
          res_tbs_r     <= rec_rdata[hrt_pkg::TBS_W-1:0];
          state_r       <= S_RESP;
        end
        S_SW_RD: begin
          state_r <= S_SW_CHK;
        end
        S_SW_CHK: begin
          k_r <= '0;
          if (expire) begin
            if (free_r < hrt_pkg::FREE_FULL) begin
              free_r <= free_r + 1'b1;
            end
            state_r <= S_SW_CLR;
          end else if (ent_idx_r == hrt_pkg::ENT_W'(hrt_pkg::TABLE_ENTRIES - 1)) begin
            state_r <= S_RESP;
          end else begin
            ent_idx_r <= ent_idx_r + 1'b1;
            state_r   <= S_SW_RD;
          end
        end
        S_SW_CLR: begin
          k_r <= k_r + 1'b1;
          if (k_r == hrt_pkg::K_W'(hrt_pkg::RECS_PER_ENT - 1)) begin
            if (ent_idx_r == hrt_pkg::ENT_W'(hrt_pkg::TABLE_ENTRIES - 1)) begin
              state_r <= S_RESP;
            end else begin
              ent_idx_r <= ent_idx_r + 1'b1;
              state_r   <= S_SW_RD;
            end
          end
        end
        S_RESP: begin
          if (resp_go) begin
            out_valid_r   <= 1'b1;
            out_verdict_r <= res_verdict_r;
            out_tbs_r     <= res_tbs_r;
            out_free_r    <= free_r;
            state_r       <= S_IDLE;
          end else if (out_valid_r && out_tready) begin
            out_valid_r <= 1'b0;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ test/tb_top.sv @@
module tb_top;
  import hrt_pkg::*;

  // One request on the in_ stream, field by field.
  typedef struct {
    op_t          op;
    logic [15:0]  rnti;
    logic [2:0]   pid;
    logic         cw;
    logic [9:0]   frame;
    logic [3:0]   sub;
    logic         ndi_p;
    logic         ndi;
    logic [16:0]  tbs;
    logic         first;
    logic         dec;
  } grant_req_t;

  // One awaited result on the out_ stream.
  typedef struct {
    verdict_t     verdict;
    logic [16:0]  tbs;
    logic [6:0]   free_n;
  } harq_answer_t;

  // Shadow of the tracker table; computes the answer of each accepted request.
  class harq_scoreboard;
    logic [15:0]  user [TABLE_ENTRIES];
    logic [31:0]  stamp [TABLE_ENTRIES];
    logic [16:0]  r_tbs [REC_COUNT];
    logic [9:0]   r_frame [REC_COUNT];
    logic [3:0]   r_sub [REC_COUNT];
    logic         r_ndi [REC_COUNT];
    logic         r_first [REC_COUNT];
    logic         r_dec [REC_COUNT];
    logic         busy [REC_COUNT];
    logic [31:0]  ticks;
    int           free_n;
    logic [15:0]  idle_lim;
    logic [6:0]   sweep_thr;
    harq_answer_t awaited[$];
    int           mismatches;

    function new();
      ticks = 0;
      free_n = TABLE_ENTRIES;
      idle_lim = IDLE_RESET;
      sweep_thr = THR_RESET;
      mismatches = 0;
      for (int e = 0; e < TABLE_ENTRIES; e++) begin
        user[e] = '0;
        stamp[e] = '0;
        clear_records(e);
      end
    endfunction

    function void clear_records(int e);
      for (int k = 0; k < RECS_PER_ENT; k++) begin
        r_tbs[e*RECS_PER_ENT+k] = '0;
        r_frame[e*RECS_PER_ENT+k] = '0;
        r_sub[e*RECS_PER_ENT+k] = '0;
        r_ndi[e*RECS_PER_ENT+k] = 1'b0;
        r_first[e*RECS_PER_ENT+k] = 1'b1;
        r_dec[e*RECS_PER_ENT+k] = 1'b0;
        busy[e*RECS_PER_ENT+k] = 1'b0;
      end
    endfunction

    function void write_reg(logic idx, logic [15:0] value);
      if (idx == CFG_IDLE_LIMIT) idle_lim = value;
      else sweep_thr = value[6:0];
    endfunction

    // Claims the record unless it is already in flight.
    function verdict_t claim(int r, verdict_t want);
      if (busy[r]) return V_BUSY;
      busy[r] = 1'b1;
      return want;
    endfunction

    function void note_request(grant_req_t q);
      int hit;
      int fr;
      int r;
      int unsigned cur_tti;
      int unsigned prev_tti;
      int unsigned gap;
      harq_answer_t a;
      hit = -1;
      fr = -1;
      a.verdict = V_DONE;
      a.tbs = '0;
      if ((q.op == OP_CLASSIFY || q.op == OP_COMMIT) && q.rnti != 0) begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (user[i] == q.rnti) hit = i;
          else if (user[i] == 0) fr = i;
        end
      end
      r = hit * RECS_PER_ENT + q.pid * CODEWORDS + q.cw;
      case (q.op)
        OP_CLASSIFY: begin
          if (q.rnti == 0) begin
            a.verdict = V_FULL;
          end else if (hit < 0) begin
            if (fr < 0) begin
              a.verdict = V_FULL;
            end else begin
              user[fr] = q.rnti;
              stamp[fr] = ticks;
              busy[fr*RECS_PER_ENT + q.pid*CODEWORDS + q.cw] = 1'b1;
              if (free_n > 0) free_n--;
              a.verdict = V_NEW;
            end
          end else begin
            cur_tti = q.frame * 10 + q.sub;
            prev_tti = r_frame[r] * 10 + r_sub[r];
            gap = (cur_tti + 20480 - prev_tti) % 10240;
            a.tbs = r_tbs[r];
            if (gap != 8) a.verdict = claim(r, V_NEW);
            else if ((q.ndi_p && q.ndi != r_ndi[r]) || r_first[r] || r_tbs[r] != q.tbs)
              a.verdict = claim(r, V_NEW);
            else if (!r_dec[r]) a.verdict = claim(r, V_RETX);
            else a.verdict = V_DECODED;
          end
        end
        OP_COMMIT: begin
          if (hit >= 0) begin
            r_tbs[r] = q.tbs;
            r_frame[r] = q.frame;
            r_sub[r] = q.sub;
            r_ndi[r] = q.ndi;
            r_first[r] = q.first;
            r_dec[r] = q.dec;
            busy[r] = 1'b0;
            stamp[hit] = ticks;
            a.tbs = q.tbs;
          end
        end
        OP_TICK: ticks = ticks + 1;
        default: begin
          if (free_n <= sweep_thr) begin
            for (int e = 0; e < TABLE_ENTRIES; e++) begin
              if (user[e] != 0 && (ticks - stamp[e]) > {16'd0, idle_lim}) begin
                user[e] = '0;
                stamp[e] = '0;
                clear_records(e);
                if (free_n < TABLE_ENTRIES) free_n++;
              end
            end
          end
        end
      endcase
      a.free_n = free_n[6:0];
      awaited = {awaited, a};
    endfunction

    function void check_result(verdict_t v, logic [16:0] tbs, logic [6:0] fc);
      harq_answer_t a;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: verdict %0d tbs %0d free %0d",
                                       v, tbs, fc);
        return;
      end
      a = awaited.pop_front();
      if (a.verdict !== v || a.tbs !== tbs || a.free_n !== fc) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected verdict %0d tbs %0d free %0d, got %0d %0d %0d",
                   a.verdict, a.tbs, a.free_n, v, tbs, fc);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic [55:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [15:0] cfg_data;

  harq_scoreboard sb = new();
  int idle_pct = 0;
  int stall_pct = 0;

  harq_retransmission_tracker u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Results are checked at the edge that accepts them.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(verdict_t'(out_tuser), out_tdata[16:0], out_tdata[23:17]);
  end

  task automatic send_request(grant_req_t q);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= q.op;
    in_tdata <= {1'b0, q.dec, q.first, q.tbs, q.ndi, q.ndi_p, q.sub, q.frame,
                 q.cw, q.pid, q.rnti};
    do @(posedge clk); while (!in_tready);
    sb.note_request(q);
  endtask

  task automatic write_reg(logic idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, value);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.awaited.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic grant_req_t make_req(op_t op, logic [15:0] rnti, int unsigned tti);
    grant_req_t q;
    q.op = op;
    q.rnti = rnti;
    q.pid = 3'($urandom_range(7));
    q.cw = 1'($urandom_range(1));
    q.frame = 10'(tti / 10);
    q.sub = 4'(tti % 10);
    q.ndi_p = 1'($urandom_range(1));
    q.ndi = 1'($urandom_range(1));
    q.tbs = 17'(($urandom_range(3) == 0) ? $urandom_range(131071) : $urandom_range(15));
    q.first = ($urandom_range(3) == 0);
    q.dec = 1'($urandom_range(1));
    return q;
  endfunction

  // Grant, usually a commit, then a follow-up for the same process, mostly eight subframes later.
  task automatic grant_flow(logic [15:0] rnti);
    grant_req_t q;
    int unsigned t;
    t = $urandom_range(10239);
    q = make_req(OP_CLASSIFY, rnti, t);
    send_request(q);
    if ($urandom_range(4) != 0) begin
      q.op = OP_COMMIT;
      q.first = ($urandom_range(3) == 0);
      q.dec = 1'($urandom_range(1));
      send_request(q);
    end
    t = (t + (($urandom_range(5) == 0) ? $urandom_range(12) : 8)) % 10240;
    q.op = OP_CLASSIFY;
    q.frame = 10'(t / 10);
    q.sub = 4'(t % 10);
    if ($urandom_range(5) == 0) q.ndi = ~q.ndi;
    if ($urandom_range(7) == 0) q.tbs = q.tbs + 17'd1;
    send_request(q);
  endtask

  task automatic random_phase(int n, int pool);
    grant_req_t q;
    int k;
    for (int i = 0; i < n; i += k) begin
      k = 1;
      case ($urandom_range(9))
        0, 1, 2, 3, 4: begin
          grant_flow(16'($urandom_range(pool, 1)));
          k = 3;
        end
        5: send_request(make_req(OP_TICK, '0, 0));
        6: send_request(make_req(OP_SWEEP, '0, 0));
        default: begin
          q = make_req(op_t'($urandom_range(3)), 16'($urandom_range(pool, 1)),
                       $urandom_range(10239));
          if ($urandom_range(3) == 0) q.rnti = 16'($urandom_range(65535));
          q.sub = 4'($urandom_range(15));
          q.tbs = 17'($urandom_range(131071));
          send_request(q);
        end
      endcase
    end
  endtask

  task automatic directed_part();
    grant_req_t q;
    q = make_req(OP_CLASSIFY, '0, 0);
    send_request(q);
    q.op = OP_COMMIT;
    send_request(q);
    // Commit for a user not in the table.
    q = make_req(OP_COMMIT, 16'hFFFF, 10239);
    send_request(q);
    // Allocation at the top of every field, then busy on the repeat.
    q = make_req(OP_CLASSIFY, 16'hFFFF, 10239);
    q.pid = 3'd7;
    q.cw = 1'b1;
    q.tbs = 17'h1FFFF;
    q.ndi = 1'b1;
    q.ndi_p = 1'b1;
    send_request(q);
    send_request(q);
    q.op = OP_COMMIT;
    q.first = 1'b0;
    q.dec = 1'b0;
    send_request(q);
    // Eight subframes later across the wrap: retransmission, then busy.
    q.op = OP_CLASSIFY;
    q.frame = 10'd0;
    q.sub = 4'd7;
    send_request(q);
    send_request(q);
    q.op = OP_COMMIT;
    q.dec = 1'b1;
    send_request(q);
    q.op = OP_CLASSIFY;
    q.frame = 10'd1;
    q.sub = 4'd5;
    send_request(q);
    // Toggled indicator forces new data.
    q.op = OP_COMMIT;
    send_request(q);
    q.op = OP_CLASSIFY;
    q.frame = 10'd2;
    q.sub = 4'd3;
    q.ndi = 1'b0;
    send_request(q);
    // Subframe outside the frame.
    q = make_req(OP_CLASSIFY, 16'h0001, 0);
    q.sub = 4'd15;
    q.frame = 10'd1023;
    send_request(q);
    send_request(make_req(OP_TICK, '0, 0));
    send_request(make_req(OP_SWEEP, '0, 0));
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OP_CLASSIFY;
    cfg_valid = 1'b0;
    cfg_index = CFG_IDLE_LIMIT;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings, no idling.
    directed_part();
    random_phase(80, 40);
    drain();

    // Nothing ever goes idle; the table fills up.
    idle_pct = 47;
    write_reg(CFG_IDLE_LIMIT, 16'hFFFF);
    write_reg(CFG_SWEEP_THR, 16'd64);
    random_phase(100, 90);
    drain();

    // Everything idle, sweeps always act.
    idle_pct = 0;
    stall_pct = 47;
    write_reg(CFG_IDLE_LIMIT, 16'd0);
    write_reg(CFG_SWEEP_THR, 16'hFF7F);
    random_phase(100, 90);
    drain();

    // Sweeps act only on a full table.
    idle_pct = 23;
    stall_pct = 23;
    write_reg(CFG_IDLE_LIMIT, 16'd3);
    write_reg(CFG_SWEEP_THR, 16'd0);
    random_phase(100, 90);
    drain();

    if (sb.mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Hard stop if the block hangs.
  initial begin
    #60000000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
